FILE: rtl/core/ftsn_pkg.sv
`timescale 1ns / 1ps

package ftsn_pkg;

    // Default timestamp width in bits (microseconds, two's complement).
    localparam int PTS_WIDTH_DEF = 48;

    // Fixed field widths.
    localparam int DUR_W  = 32;
    localparam int FPS_W  = 10;
    localparam int JUMP_W = 16;
    localparam int REASON_W = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE   = 2'd0,
        REG_FPS      = 2'd1,
        REG_MAX_JUMP = 2'd2
    } reg_idx_t;

    // Register reset values.
    localparam logic             ENABLE_RST   = 1'b1;
    localparam logic [FPS_W-1:0] FPS_RST      = 10'd30;
    localparam logic [JUMP_W-1:0] MAX_JUMP_RST = 16'd1000;

    // Fallback duration is 1000000 / fps, done one quotient bit per cycle.
    localparam int               DIV_BITS     = 20;
    localparam int               DIV_CNT_W    = 5;
    localparam logic [DIV_BITS-1:0] FPS_DIVIDEND = 20'd1000000;

    // Milliseconds to microseconds for the jump limit.
    localparam int               LIMIT_W   = 26;
    localparam logic [LIMIT_W-1:0] MS_TO_US = 26'd1000;

    typedef enum logic [REASON_W-1:0] {
        REASON_NONE     = 2'd0,
        REASON_MISSING  = 2'd1,
        REASON_BACKWARD = 2'd2,
        REASON_JUMP     = 2'd3
    } reason_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXP,
        ST_CHK,
        ST_ABS,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/core/frame_timestamp_normalizer.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Content
// ----------+-----------+----------------------+------------------------------------------
// s_*       | in        | s_tvalid / s_tready  | tdata: input_pts, frame_duration; tuser: cmd
// m_*       | out       | m_tvalid / m_tready  | tdata: output_pts; tuser: was_changed, reason_code
// APB       | in/out    | psel & penable       | enable_normalize @0, frame_rate @4,
//           |           |                      | jump_limit_ms @8
//
// A frame goes straight to the output step when normalization is off or on the first frame. With a
// known duration it passes the expected-time, check and output steps (the magnitude step runs only
// when the jump check has to decide); when the fallback duration is needed, a restoring divide
// of 1000000 by the frame rate on the shared adder comes first.
// A clear command produces no transfer on the output.
// Reset clears the registers to their defaults and drops the timestamp history.
// The output register holds a result until it is taken; a new frame is accepted meanwhile,
// and the sequencer waits only if its next result finds the output register still full.

module frame_timestamp_normalizer #(
    parameter int PTS_WIDTH = ftsn_pkg::PTS_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [PTS_WIDTH-1:0] input_pts, [PTS_WIDTH+31:PTS_WIDTH] frame_duration, zero pad above
    input  logic [((PTS_WIDTH+ftsn_pkg::DUR_W+7)/8)*8-1:0] s_tdata,
    // [0] cmd
    input  logic                                   s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [PTS_WIDTH-1:0] output_pts, zero pad above
    output logic [((PTS_WIDTH+7)/8)*8-1:0]         m_tdata,
    // [0] was_changed, [2:1] reason_code
    output logic [2:0]                             m_tuser,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ftsn_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [ftsn_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [ftsn_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int W        = PTS_WIDTH;
    localparam int AW       = PTS_WIDTH + 2;            // shared adder width
    localparam int OUT_W    = ((PTS_WIDTH + 7) / 8) * 8;
    localparam logic [W-1:0]  PTS_MAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [AW-1:0] PTS_MAX_EXT = {3'b000, {(W-1){1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                              en_reg;
    logic [ftsn_pkg::FPS_W-1:0]        fps_reg;
    logic [ftsn_pkg::JUMP_W-1:0]       jump_reg;
    logic                              cfg_wr;
    logic                              cfg_hit;
    ftsn_pkg::reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = ftsn_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_hit = 1'b0;
        prdata  = '0;
        unique case (cfg_idx)
            ftsn_pkg::REG_ENABLE:
            begin
                cfg_hit = 1'b1;
                prdata  = {{(ftsn_pkg::APB_DATA_W-1){1'b0}}, en_reg};
            end
            ftsn_pkg::REG_FPS:
            begin
                cfg_hit = 1'b1;
                prdata  = {{(ftsn_pkg::APB_DATA_W-ftsn_pkg::FPS_W){1'b0}}, fps_reg};
            end
            ftsn_pkg::REG_MAX_JUMP:
            begin
                cfg_hit = 1'b1;
                prdata  = {{(ftsn_pkg::APB_DATA_W-ftsn_pkg::JUMP_W){1'b0}}, jump_reg};
            end
            default:
            begin
                cfg_hit = 1'b0;
                prdata  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= ftsn_pkg::ENABLE_RST;
            fps_reg  <= ftsn_pkg::FPS_RST;
            jump_reg <= ftsn_pkg::MAX_JUMP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                ftsn_pkg::REG_ENABLE:   en_reg   <= pwdata[0];
                ftsn_pkg::REG_FPS:      fps_reg  <= pwdata[ftsn_pkg::FPS_W-1:0];
                ftsn_pkg::REG_MAX_JUMP: jump_reg <= pwdata[ftsn_pkg::JUMP_W-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    ftsn_pkg::state_t                  state_reg, state_next;
    logic                              hist_reg, hist_next;
    logic signed [W-1:0]               prev_raw_reg, prev_raw_next;
    logic signed [W-1:0]               prev_out_reg, prev_out_next;

    logic signed [W-1:0]               pts_reg, pts_next;
    logic [ftsn_pkg::DUR_W-1:0]        step_reg, step_next;
    logic signed [W-1:0]               exp_reg, exp_next;
    logic [AW-1:0]                     diff_reg, diff_next;
    logic [ftsn_pkg::FPS_W-1:0]        rem_reg, rem_next;
    logic [ftsn_pkg::DIV_BITS-1:0]     quot_reg, quot_next;
    logic [ftsn_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic signed [W-1:0]               res_reg, res_next;
    ftsn_pkg::reason_t                 reason_reg, reason_next;

    logic                              m_valid_reg, m_valid_next;
    logic [W-1:0]                      m_pts_reg, m_pts_next;
    logic                              m_chg_reg, m_chg_next;
    ftsn_pkg::reason_t                 m_reason_reg, m_reason_next;

    // ------------------------------------------------------------------
    // Shared add/subtract unit
    // ------------------------------------------------------------------
    logic [AW-1:0]                     alu_a;
    logic [AW-1:0]                     alu_b;
    logic                              alu_sub;
    logic [AW-1:0]                     alu_sum;

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(AW-1){1'b0}}, alu_sub};

    // ------------------------------------------------------------------
    // Input unpacking and helpers
    // ------------------------------------------------------------------
    logic signed [W-1:0]               in_pts;
    logic signed [ftsn_pkg::DUR_W-1:0] in_dur;
    logic [ftsn_pkg::FPS_W-1:0]        divisor;
    logic [ftsn_pkg::FPS_W:0]          rem_shift;
    logic [ftsn_pkg::LIMIT_W-1:0]      jump_limit;
    logic [AW-1:0]                     abs_diff;
    logic                              in_take;
    logic                              pts_missing;
    logic                              pts_backward;

    assign in_pts  = s_tdata[W-1:0];
    assign in_dur  = s_tdata[W+ftsn_pkg::DUR_W-1:W];
    assign in_take = s_tvalid & s_tready;

    // A rate of zero divides as one.
    assign divisor   = (fps_reg == '0) ? {{(ftsn_pkg::FPS_W-1){1'b0}}, 1'b1} : fps_reg;
    assign rem_shift = {rem_reg, quot_reg[ftsn_pkg::DIV_BITS-1]};

    assign jump_limit = ftsn_pkg::LIMIT_W'(jump_reg) * ftsn_pkg::MS_TO_US;

    // Timestamps that are negative, zero or equal to the previous raw input count as missing; below it, as backward.
    assign pts_missing  = pts_reg[W-1] || (pts_reg == '0) || (pts_reg == prev_raw_reg);
    assign pts_backward = pts_reg < prev_raw_reg;

    // In the magnitude step the adder forms expected - pts when the difference was negative.
    assign abs_diff = diff_reg[AW-1] ? alu_sum : diff_reg;

    assign s_tready = (state_reg == ftsn_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        hist_next     = hist_reg;
        prev_raw_next = prev_raw_reg;
        prev_out_next = prev_out_reg;
        pts_next      = pts_reg;
        step_next     = step_reg;
        exp_next      = exp_reg;
        diff_next     = diff_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        reason_next   = reason_reg;

        m_valid_next  = m_valid_reg & ~m_tready;
        m_pts_next    = m_pts_reg;
        m_chg_next    = m_chg_reg;
        m_reason_next = m_reason_reg;

        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;

        unique case (state_reg)
            ftsn_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    pts_next = in_pts;
                    if (s_tuser)
                    begin
                        // Clear command: drop the history, no result.
                        hist_next     = 1'b0;
                        prev_raw_next = '0;
                        prev_out_next = '0;
                    end
                    else if (!en_reg)
                    begin
                        res_next    = in_pts;
                        reason_next = ftsn_pkg::REASON_NONE;
                        state_next  = ftsn_pkg::ST_OUT;
                    end
                    else if (!hist_reg)
                    begin
                        // First frame: clamp to zero and start the history.
                        res_next      = in_pts[W-1] ? '0 : in_pts;
                        reason_next   = in_pts[W-1] ? ftsn_pkg::REASON_MISSING
                                                    : ftsn_pkg::REASON_NONE;
                        hist_next     = 1'b1;
                        prev_raw_next = in_pts;
                        prev_out_next = in_pts[W-1] ? '0 : in_pts;
                        state_next    = ftsn_pkg::ST_OUT;
                    end
                    else if (!in_dur[ftsn_pkg::DUR_W-1] && (in_dur != '0))
                    begin
                        step_next  = in_dur;
                        state_next = ftsn_pkg::ST_EXP;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quot_next  = ftsn_pkg::FPS_DIVIDEND;
                        cnt_next   = ftsn_pkg::DIV_CNT_W'(ftsn_pkg::DIV_BITS - 1);
                        state_next = ftsn_pkg::ST_DIV;
                    end
                end
            end

            ftsn_pkg::ST_DIV:
            begin
                // Restoring divide, one quotient bit per cycle.
                alu_a   = AW'(rem_shift);
                alu_b   = AW'(divisor);
                alu_sub = 1'b1;
                if (!alu_sum[AW-1])
                begin
                    rem_next  = alu_sum[ftsn_pkg::FPS_W-1:0];
                    quot_next = {quot_reg[ftsn_pkg::DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[ftsn_pkg::FPS_W-1:0];
                    quot_next = {quot_reg[ftsn_pkg::DIV_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    step_next  = ftsn_pkg::DUR_W'(quot_next);
                    state_next = ftsn_pkg::ST_EXP;
                end
            end

            ftsn_pkg::ST_EXP:
            begin
                // Expected time, saturated at the top of the field.
                alu_a = {{2{prev_out_reg[W-1]}}, prev_out_reg};
                alu_b = AW'(step_reg);
                if ($signed(alu_sum) > $signed(PTS_MAX_EXT))
                begin
                    exp_next = PTS_MAX;
                end
                else
                begin
                    exp_next = alu_sum[W-1:0];
                end
                state_next = ftsn_pkg::ST_CHK;
            end

            ftsn_pkg::ST_CHK:
            begin
                alu_a     = {{2{pts_reg[W-1]}}, pts_reg};
                alu_b     = {{2{exp_reg[W-1]}}, exp_reg};
                alu_sub   = 1'b1;
                diff_next = alu_sum;
                res_next  = pts_reg;
                state_next = ftsn_pkg::ST_OUT;
                if (pts_missing)
                begin
                    reason_next = ftsn_pkg::REASON_MISSING;
                    res_next    = exp_reg;
                end
                else if (pts_backward)
                begin
                    reason_next = ftsn_pkg::REASON_BACKWARD;
                    res_next    = exp_reg;
                end
                else if (jump_reg == '0)
                begin
                    reason_next = ftsn_pkg::REASON_NONE;
                end
                else
                begin
                    state_next = ftsn_pkg::ST_ABS;
                end
                if (state_next == ftsn_pkg::ST_OUT)
                begin
                    prev_raw_next = pts_reg;
                    prev_out_next = res_next;
                end
            end

            ftsn_pkg::ST_ABS:
            begin
                alu_a   = {{2{exp_reg[W-1]}}, exp_reg};
                alu_b   = {{2{pts_reg[W-1]}}, pts_reg};
                alu_sub = 1'b1;
                if (abs_diff > AW'(jump_limit))
                begin
                    reason_next = ftsn_pkg::REASON_JUMP;
                    res_next    = exp_reg;
                end
                else
                begin
                    reason_next = ftsn_pkg::REASON_NONE;
                    res_next    = pts_reg;
                end
                prev_raw_next = pts_reg;
                prev_out_next = res_next;
                state_next    = ftsn_pkg::ST_OUT;
            end

            ftsn_pkg::ST_OUT:
            begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_pts_next    = res_reg;
                    m_chg_next    = (res_reg != pts_reg);
                    m_reason_next = reason_reg;
                    state_next    = ftsn_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ftsn_pkg::ST_IDLE;
            end
        endcase

        // Any register write drops the history.
        if (cfg_wr && cfg_hit)
        begin
            hist_next     = 1'b0;
            prev_raw_next = '0;
            prev_out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ftsn_pkg::ST_IDLE;
            hist_reg     <= 1'b0;
            prev_raw_reg <= '0;
            prev_out_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            hist_reg     <= hist_next;
            prev_raw_reg <= prev_raw_next;
            prev_out_reg <= prev_out_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg      <= pts_next;
        step_reg     <= step_next;
        exp_reg      <= exp_next;
        diff_reg     <= diff_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        res_reg      <= res_next;
        reason_reg   <= reason_next;
        m_pts_reg    <= m_pts_next;
        m_chg_reg    <= m_chg_next;
        m_reason_reg <= m_reason_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_pts_reg);
    assign m_tuser  = {m_reason_reg, m_chg_reg};

endmodule
